// ----- rtl/core/mrs_pkg.sv -----
// shared constants, marker table and inter-module structs for the marker record splitter
// depends on nothing; imported by every module of the block
package mrs_pkg;

    localparam int MARKER_LEN       = 17;
    localparam int WIN_LEN          = MARKER_LEN - 1;
    localparam int BLOCK_INDEX_BITS = 16;
    localparam int THRESH_W         = 32;
    localparam int PADDR_W          = 3;
    localparam int OBUF_DEPTH       = 2;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 32'd1048576;

    // register index, taken from paddr[2]
    localparam logic REG_IDX_THRESHOLD = 1'b0;

    // molecule section header marker, zero padded to 32 entries
    localparam logic [7:0] MARKER_TAB [32] = '{
        8'h40, 8'h3C, 8'h54, 8'h52, 8'h49, 8'h50, 8'h4F, 8'h53,
        8'h3E, 8'h4D, 8'h4F, 8'h4C, 8'h45, 8'h43, 8'h55, 8'h4C,
        8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic valid;
        logic match;
        logic last;
    } emit_req_t;

    typedef struct packed {
        logic [7:0]                  out_byte;
        logic [BLOCK_INDEX_BITS-1:0] block_index;
        logic                        record_start;
        logic                        block_start;
        logic                        last;
    } out_item_t;

endpackage

// ----- rtl/core/mrs_cell.sv -----
// one lookahead cell: holds a byte and its valid flag, compares it with its marker byte
// depends on mrs_pkg
module mrs_cell
    import mrs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift_en,
    input  logic [7:0] nb_data,
    input  logic       nb_valid,
    input  logic [7:0] ref_byte,
    output logic [7:0] data,
    output logic       valid,
    output logic       hit
);

    logic [7:0] data_reg;
    logic       valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= nb_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= nb_data;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign hit   = (data_reg == ref_byte);

endmodule

// ----- rtl/core/mrs_block_acct.sv -----
// record and block accounting for each emitted byte, builds the result item
// depends on mrs_pkg
module mrs_block_acct
    import mrs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [THRESH_W-1:0] threshold,
    input  emit_req_t           req,
    input  logic [7:0]          emit_byte,
    output out_item_t           item
);

    localparam logic [31:0]                 BYTES_MAX = '1;
    localparam logic [BLOCK_INDEX_BITS-1:0] BLOCK_MAX = '1;

    logic                        first_pending_reg, first_pending_next;
    logic [31:0]                 bytes_reg, bytes_next;
    logic [BLOCK_INDEX_BITS-1:0] block_reg, block_next;

    logic [31:0]                 bytes_base;
    logic [BLOCK_INDEX_BITS-1:0] block_emit;
    logic                        rec;
    logic                        blk;

    always_comb begin
        first_pending_next = first_pending_reg;
        bytes_next         = bytes_reg;
        block_next         = block_reg;
        bytes_base         = bytes_reg;
        block_emit         = block_reg;
        rec                = 1'b0;
        blk                = 1'b0;
        if (req.valid) begin
            if (first_pending_reg) begin
                rec                = 1'b1;
                blk                = 1'b1;
                first_pending_next = 1'b0;
                bytes_base         = '0;
            end else if (req.match) begin
                rec = 1'b1;
                if (bytes_reg >= threshold) begin
                    blk        = 1'b1;
                    bytes_base = '0;
                    if (block_reg != BLOCK_MAX) begin
                        block_emit = block_reg + 1'b1;
                    end
                end
            end
            bytes_next = (bytes_base == BYTES_MAX) ? bytes_base : bytes_base + 32'd1;
            block_next = block_emit;
            // final byte of the stream: back to stream reset state
            if (req.last) begin
                first_pending_next = 1'b1;
                bytes_next         = '0;
                block_next         = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_pending_reg <= 1'b1;
            bytes_reg         <= '0;
            block_reg         <= '0;
        end else begin
            first_pending_reg <= first_pending_next;
            bytes_reg         <= bytes_next;
            block_reg         <= block_next;
        end
    end

    assign item.out_byte     = emit_byte;
    assign item.block_index  = block_emit;
    assign item.record_start = rec;
    assign item.block_start  = blk;
    assign item.last         = req.last;

endmodule

// ----- rtl/core/mrs_out_buf.sv -----
// two-entry result buffer that decouples the window from the result channel
// depends on mrs_pkg
module mrs_out_buf
    import mrs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_item_t push_item,
    output logic      full,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t head
);

    localparam int PTR_W = $clog2(OBUF_DEPTH);
    localparam int CNT_W = $clog2(OBUF_DEPTH + 1);

    out_item_t              buf_reg [OBUF_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   pop;

    assign pop = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full      = (count_reg == CNT_W'(OBUF_DEPTH));
    assign out_valid = (count_reg != '0);
    assign head      = buf_reg[rd_ptr_reg];

endmodule

// ----- rtl/core/marker_record_splitter.sv -----
// a byte leaves once 16 more bytes were requested, then is registered in the result buffer
// 1 byte per cycle while the buffer has room; an end of stream adds a flush of the cell chain
// (one cell shift per cycle, held off only while the two-entry result buffer is full)
// reset: aresetn synchronous active low, empties window and buffer, threshold to 1048576
// top level of the marker record splitter; depends on mrs_pkg, mrs_cell,
// mrs_block_acct and mrs_out_buf
module marker_record_splitter
    import mrs_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_W-1:0]          paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // byte requests in
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_in_byte,
    input  logic                        s_end_of_stream,
    // result requests out
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_byte,
    output logic [BLOCK_INDEX_BITS-1:0] m_block_index,
    output logic                        m_record_start,
    output logic                        m_block_start,
    output logic                        m_last
);

    // configuration register
    logic [THRESH_W-1:0] threshold_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_THRESHOLD);
    assign prdata = (paddr[2] == REG_IDX_THRESHOLD) ? threshold_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_wr) begin
            threshold_reg <= pwdata;
        end
    end

    // flush control
    logic flush_reg, flush_next;
    logic buf_full;
    logic in_acc;
    logic flush_step;
    logic shift_en;
    logic single;
    logic last_emit;
    logic all_hit;

    // chain taps: index 0 is the oldest byte, index WIN_LEN is what enters the tail cell
    logic [7:0]         chain_data  [WIN_LEN+1];
    logic [WIN_LEN:0]   chain_valid;
    logic [WIN_LEN-1:0] cell_hit;

    emit_req_t emit_req;
    out_item_t emit_item;
    out_item_t head;

    assign s_ready    = !flush_reg && !buf_full;
    assign in_acc     = s_valid && s_ready;
    // during the flush, idle shifts need no buffer space
    assign flush_step = flush_reg && (!chain_valid[0] || !buf_full);
    assign shift_en   = in_acc || flush_step;

    // a stream of one byte: tail cell still empty when the end mark arrives
    assign single = s_end_of_stream && !chain_valid[WIN_LEN-1];

    // new bytes enter the tail, zeros are shifted in while flushing
    assign chain_data[WIN_LEN]  = in_acc ? s_in_byte : 8'h00;
    assign chain_valid[WIN_LEN] = in_acc && !single;

    genvar gi;
    generate
        for (gi = 0; gi < WIN_LEN; gi++) begin : g_cell
            mrs_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .nb_data  (chain_data[gi+1]),
                .nb_valid (chain_valid[gi+1]),
                .ref_byte (MARKER_TAB[gi]),
                .data     (chain_data[gi]),
                .valid    (chain_valid[gi]),
                .hit      (cell_hit[gi])
            );
        end
    endgenerate

    // marker starts at the oldest byte when every cell and the arriving byte agree
    assign all_hit = (&cell_hit) && (s_in_byte == MARKER_TAB[WIN_LEN]);

    // the oldest byte leaves on every shift that finds it valid
    assign last_emit      = flush_step && chain_valid[0] && !chain_valid[1];
    assign emit_req.valid = shift_en && chain_valid[0];
    assign emit_req.match = in_acc && all_hit;
    assign emit_req.last  = last_emit;

    always_comb begin
        flush_next = flush_reg;
        if (in_acc && s_end_of_stream && !single) begin
            flush_next = 1'b1;
        end else if (last_emit) begin
            flush_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_reg <= 1'b0;
        end else begin
            flush_reg <= flush_next;
        end
    end

    mrs_block_acct u_acct (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .threshold (threshold_reg),
        .req       (emit_req),
        .emit_byte (chain_data[0]),
        .item      (emit_item)
    );

    mrs_out_buf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (emit_req.valid),
        .push_item (emit_item),
        .full      (buf_full),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .head      (head)
    );

    assign m_out_byte     = head.out_byte;
    assign m_block_index  = head.block_index;
    assign m_record_start = head.record_start;
    assign m_block_start  = head.block_start;
    assign m_last         = head.last;

endmodule

// ----- rtl/core/mrs_checker.sv -----
// port-level checks for the marker record splitter, bound to the top level
// depends on mrs_pkg and marker_record_splitter
module mrs_checker
    import mrs_pkg::*;
(
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [7:0]                  m_out_byte,
    input logic [BLOCK_INDEX_BITS-1:0] m_block_index,
    input logic                        m_record_start,
    input logic                        m_block_start,
    input logic                        m_last
);

    // stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_block_index) && $stable(m_record_start)
            && $stable(m_block_start) && $stable(m_last))
        else $error("stalled result changed");

    // a block always opens on a record boundary
    a_blk_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_block_start |-> m_record_start)
        else $error("block start without record start");

    // reset empties the result buffer
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // reset leaves the block ready for a new stream
    a_rst_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("not ready after reset");

endmodule

bind marker_record_splitter mrs_checker u_mrs_checker (.*);
